// ----- rtl/sicxe_pkg.sv -----
`default_nettype none
package sicxe_pkg;

    // Address and field widths
    localparam int ADDR_WIDTH_DEF = 24;
    localparam int ADDR_OUT_W     = 24;
    localparam int LOAD_W         = 24;
    localparam int OPIDX_W        = 6;
    localparam int FMT_W          = 3;
    localparam int FIELD_W        = 20;
    localparam int DISP_W         = 12;
    localparam int QUEUE_DEPTH    = 2;

    // Input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Instruction formats
    localparam logic [FMT_W-1:0] FMT_NONE = 3'd0;
    localparam logic [FMT_W-1:0] FMT_1    = 3'd1;
    localparam logic [FMT_W-1:0] FMT_2    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_3    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_4    = 3'd4;

    // Addressing modes
    localparam logic [1:0] MODE_SIMPLE    = 2'd0;
    localparam logic [1:0] MODE_IMMEDIATE = 2'd1;
    localparam logic [1:0] MODE_INDIRECT  = 2'd2;

    // n/i encodings
    localparam logic [1:0] NI_IMMEDIATE = 2'b01;
    localparam logic [1:0] NI_INDIRECT  = 2'b10;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OPCODE  = 2'd1;
    localparam logic [1:0] ERR_REGNUM  = 2'd2;

    // Highest legal register number
    localparam logic [3:0] REG_MAX = 4'd6;

    // LDB opcode with the n/i bits dropped
    localparam logic [5:0] OP6_LDB = 6'h1A;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  byte_value;
        logic [LOAD_W-1:0] load_address;
    } dec_in_t;

    typedef struct packed {
        logic [ADDR_OUT_W-1:0] inst_address;
        logic [OPIDX_W-1:0]    opcode_index;
        logic [FMT_W-1:0]      format;
        logic [5:0]            flag_bits;
        logic [1:0]            addr_mode;
        logic [FIELD_W-1:0]    operand_field;
        logic [3:0]            reg_first;
        logic [3:0]            reg_second;
        logic [ADDR_OUT_W-1:0] target_address;
        logic                  sets_base;
        logic [1:0]            error_code;
    } dec_out_t;

    // Assembled instruction handed from front to back
    typedef struct packed {
        logic [ADDR_OUT_W-1:0] inst_address;
        logic [OPIDX_W-1:0]    opcode_index;
        logic [FMT_W-1:0]      format;
        logic                  unknown;
        logic [7:0]            byte0;
        logic [7:0]            byte1;
        logic [7:0]            byte2;
        logic [7:0]            byte3;
    } inst_rec_t;

    typedef struct packed {
        logic               known;
        logic [OPIDX_W-1:0] idx;
        logic [FMT_W-1:0]   fmt;
    } op_info_t;

    // Opcode table, keyed by the opcode with its low two bits dropped
    function automatic op_info_t op_lookup(input logic [5:0] op6);
        op_info_t r;
        r = '{known: 1'b0, idx: '0, fmt: FMT_1};
        unique case (op6)
            6'd6:  r = '{1'b1, 6'd0,  FMT_3};
            6'd22: r = '{1'b1, 6'd1,  FMT_3};
            6'd36: r = '{1'b1, 6'd2,  FMT_2};
            6'd16: r = '{1'b1, 6'd3,  FMT_3};
            6'd45: r = '{1'b1, 6'd4,  FMT_2};
            6'd10: r = '{1'b1, 6'd5,  FMT_3};
            6'd34: r = '{1'b1, 6'd6,  FMT_3};
            6'd40: r = '{1'b1, 6'd7,  FMT_2};
            6'd9:  r = '{1'b1, 6'd8,  FMT_3};
            6'd25: r = '{1'b1, 6'd9,  FMT_3};
            6'd39: r = '{1'b1, 6'd10, FMT_2};
            6'd49: r = '{1'b1, 6'd11, FMT_1};
            6'd48: r = '{1'b1, 6'd12, FMT_1};
            6'd61: r = '{1'b1, 6'd13, FMT_1};
            6'd15: r = '{1'b1, 6'd14, FMT_3};
            6'd12: r = '{1'b1, 6'd15, FMT_3};
            6'd13: r = '{1'b1, 6'd16, FMT_3};
            6'd14: r = '{1'b1, 6'd17, FMT_3};
            6'd18: r = '{1'b1, 6'd18, FMT_3};
            6'd0:  r = '{1'b1, 6'd19, FMT_3};
            6'd26: r = '{1'b1, 6'd20, FMT_3};
            6'd20: r = '{1'b1, 6'd21, FMT_3};
            6'd28: r = '{1'b1, 6'd22, FMT_3};
            6'd2:  r = '{1'b1, 6'd23, FMT_3};
            6'd27: r = '{1'b1, 6'd24, FMT_3};
            6'd29: r = '{1'b1, 6'd25, FMT_3};
            6'd1:  r = '{1'b1, 6'd26, FMT_3};
            6'd52: r = '{1'b1, 6'd27, FMT_3};
            6'd8:  r = '{1'b1, 6'd28, FMT_3};
            6'd24: r = '{1'b1, 6'd29, FMT_3};
            6'd38: r = '{1'b1, 6'd30, FMT_2};
            6'd50: r = '{1'b1, 6'd31, FMT_1};
            6'd17: r = '{1'b1, 6'd32, FMT_3};
            6'd54: r = '{1'b1, 6'd33, FMT_3};
            6'd43: r = '{1'b1, 6'd34, FMT_2};
            6'd19: r = '{1'b1, 6'd35, FMT_3};
            6'd41: r = '{1'b1, 6'd36, FMT_2};
            6'd42: r = '{1'b1, 6'd37, FMT_2};
            6'd60: r = '{1'b1, 6'd38, FMT_1};
            6'd59: r = '{1'b1, 6'd39, FMT_3};
            6'd3:  r = '{1'b1, 6'd40, FMT_3};
            6'd30: r = '{1'b1, 6'd41, FMT_3};
            6'd21: r = '{1'b1, 6'd42, FMT_3};
            6'd32: r = '{1'b1, 6'd43, FMT_3};
            6'd53: r = '{1'b1, 6'd44, FMT_3};
            6'd5:  r = '{1'b1, 6'd45, FMT_3};
            6'd31: r = '{1'b1, 6'd46, FMT_3};
            6'd58: r = '{1'b1, 6'd47, FMT_3};
            6'd33: r = '{1'b1, 6'd48, FMT_3};
            6'd4:  r = '{1'b1, 6'd49, FMT_3};
            6'd7:  r = '{1'b1, 6'd50, FMT_3};
            6'd23: r = '{1'b1, 6'd51, FMT_3};
            6'd37: r = '{1'b1, 6'd52, FMT_2};
            6'd44: r = '{1'b1, 6'd53, FMT_2};
            6'd56: r = '{1'b1, 6'd54, FMT_3};
            6'd62: r = '{1'b1, 6'd55, FMT_1};
            6'd11: r = '{1'b1, 6'd56, FMT_3};
            6'd46: r = '{1'b1, 6'd57, FMT_2};
            6'd55: r = '{1'b1, 6'd58, FMT_3};
            default: r = '{known: 1'b0, idx: '0, fmt: FMT_1};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sicxe_front.sv -----
`default_nettype none
module sicxe_front
    import sicxe_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire dec_in_t   byte_item,
    output logic           push,
    output inst_rec_t      push_rec,
    input  wire logic      queue_full
);

    logic [ADDR_WIDTH-1:0] lc_reg, lc_next;
    logic [ADDR_WIDTH-1:0] start_reg, start_next;
    logic [2:0]            held_reg, held_next;
    logic [FMT_W-1:0]      exp_reg, exp_next;
    logic [7:0]            buf0_reg, buf0_next;
    logic [7:0]            buf1_reg, buf1_next;
    logic [7:0]            buf2_reg, buf2_next;
    logic [OPIDX_W-1:0]    idx_reg, idx_next;

    logic                  accept;
    op_info_t              lk;
    logic [FMT_W-1:0]      exp_sel;
    logic [2:0]            held_inc;
    logic [7:0]            b;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign b          = byte_item.byte_value;
    assign lk         = op_lookup(b[7:2]);
    assign held_inc   = 3'(held_reg + 3'd1);

    // Byte assembly and classification
    always_comb
    begin
        lc_next    = lc_reg;
        start_next = start_reg;
        held_next  = held_reg;
        exp_next   = exp_reg;
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        buf2_next  = buf2_reg;
        idx_next   = idx_reg;
        push       = 1'b0;
        push_rec   = '0;
        exp_sel    = exp_reg;

        if (held_reg == 3'd1 && exp_reg == FMT_3 && b[4])
        begin
            exp_sel = FMT_4;
        end

        if (accept)
        begin
            if (byte_item.cmd == CMD_LOAD)
            begin
                lc_next   = byte_item.load_address[ADDR_WIDTH-1:0];
                held_next = 3'd0;
                exp_next  = FMT_NONE;
            end
            else
            begin
                lc_next = lc_reg + ADDR_WIDTH'(1);
                if (held_reg == 3'd0)
                begin
                    start_next = lc_reg;
                    push_rec.inst_address = ADDR_OUT_W'(lc_reg);
                    if (!lk.known)
                    begin
                        push             = 1'b1;
                        push_rec.format  = FMT_1;
                        push_rec.unknown = 1'b1;
                    end
                    else if (lk.fmt == FMT_1)
                    begin
                        push                  = 1'b1;
                        push_rec.format       = FMT_1;
                        push_rec.opcode_index = lk.idx;
                    end
                    else
                    begin
                        buf0_next = b;
                        idx_next  = lk.idx;
                        held_next = 3'd1;
                        exp_next  = lk.fmt;
                    end
                end
                else if (held_inc == exp_sel)
                begin
                    // last byte: hand the whole instruction to the back end
                    push                  = 1'b1;
                    push_rec.inst_address = ADDR_OUT_W'(start_reg);
                    push_rec.opcode_index = idx_reg;
                    push_rec.format       = exp_sel;
                    push_rec.byte0        = buf0_reg;
                    push_rec.byte1        = (held_reg == 3'd1) ? b : buf1_reg;
                    push_rec.byte2        = (held_reg == 3'd2) ? b : buf2_reg;
                    push_rec.byte3        = b;
                    held_next             = 3'd0;
                    exp_next              = FMT_NONE;
                end
                else
                begin
                    held_next = held_inc;
                    exp_next  = exp_sel;
                    if (held_reg == 3'd1)
                    begin
                        buf1_next = b;
                    end
                    else
                    begin
                        buf2_next = b;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg    <= '0;
            start_reg <= '0;
            held_reg  <= 3'd0;
            exp_reg   <= FMT_NONE;
        end
        else
        begin
            lc_reg    <= lc_next;
            start_reg <= start_next;
            held_reg  <= held_next;
            exp_reg   <= exp_next;
        end
    end

    // Instruction bytes
    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
        buf2_reg <= buf2_next;
        idx_reg  <= idx_next;
    end

endmodule
`default_nettype wire

// ----- rtl/sicxe_queue.sv -----
`default_nettype none
module sicxe_queue
    import sicxe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire inst_rec_t push_rec,
    input  wire logic      pop,
    output logic           empty,
    output logic           full,
    output inst_rec_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    inst_rec_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = mem[rd_reg];

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == LAST) ? '0 : PTR_W'(wr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == LAST) ? '0 : PTR_W'(rd_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sicxe_back.sv -----
`default_nettype none
module sicxe_back
    import sicxe_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      queue_empty,
    input  wire inst_rec_t head,
    output logic           pop,
    output logic           inst_valid,
    input  wire logic      inst_stall,
    output dec_out_t       inst_item
);

    logic                  valid_reg;
    dec_out_t              out_reg, out_next;
    logic [ADDR_WIDTH-1:0] base_reg, base_next;

    logic [1:0]            ni;
    logic [3:0]            xbpe;
    logic [3:0]            r1;
    logic [3:0]            r2;
    logic [DISP_W-1:0]     disp;
    logic [FIELD_W-1:0]    ext;
    logic [ADDR_WIDTH-1:0] ta;
    logic [ADDR_WIDTH-1:0] pc_base;

    assign pop        = !queue_empty && (!valid_reg || !inst_stall);
    assign inst_valid = valid_reg;
    assign inst_item  = out_reg;

    assign ni      = head.byte0[1:0];
    assign xbpe    = head.byte1[7:4];
    assign r1      = head.byte1[7:4];
    assign r2      = head.byte1[3:0];
    assign disp    = {head.byte1[3:0], head.byte2};
    assign ext     = {head.byte1[3:0], head.byte2, head.byte3};
    assign pc_base = head.inst_address[ADDR_WIDTH-1:0] + ADDR_WIDTH'(3);

    // Target address for formats 3 and 4
    always_comb
    begin
        if (head.format == FMT_4)
        begin
            ta = ADDR_WIDTH'(ext);
        end
        else if (xbpe[2])
        begin
            ta = base_reg + ADDR_WIDTH'(disp);
        end
        else if (xbpe[1])
        begin
            ta = pc_base + {{(ADDR_WIDTH - DISP_W){disp[DISP_W-1]}}, disp};
        end
        else
        begin
            ta = ADDR_WIDTH'(disp);
        end
    end

    // Result assembly
    always_comb
    begin
        out_next              = '0;
        base_next             = base_reg;
        out_next.inst_address = head.inst_address;
        out_next.opcode_index = head.opcode_index;
        out_next.format       = head.format;
        if (head.unknown)
        begin
            out_next.error_code = ERR_OPCODE;
        end
        else if (head.format == FMT_2)
        begin
            out_next.reg_first  = r1;
            out_next.reg_second = r2;
            if (r1 > REG_MAX || r2 > REG_MAX)
            begin
                out_next.error_code = ERR_REGNUM;
            end
        end
        else if (head.format == FMT_3 || head.format == FMT_4)
        begin
            out_next.flag_bits      = {ni, xbpe};
            out_next.target_address = ADDR_OUT_W'(ta);
            if (ni == NI_IMMEDIATE)
            begin
                out_next.addr_mode = MODE_IMMEDIATE;
            end
            else if (ni == NI_INDIRECT)
            begin
                out_next.addr_mode = MODE_INDIRECT;
            end
            else
            begin
                out_next.addr_mode = MODE_SIMPLE;
            end
            if (head.format == FMT_4)
            begin
                out_next.operand_field = ext;
                if (head.byte0[7:2] == OP6_LDB)
                begin
                    out_next.sets_base = 1'b1;
                    base_next          = ADDR_WIDTH'(ext);
                end
            end
            else
            begin
                out_next.operand_field = FIELD_W'(disp);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            base_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                base_reg  <= base_next;
            end
            else if (!inst_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sicxe_instruction_decoder_top.sv -----
`default_nettype none
// SIC/XE instruction decoder. Takes one object-code byte or one load-address
// command per cycle on the byte channel while not stalled, and returns one
// decoded instruction on the inst channel once its last byte arrives (formats
// 1 to 4, unknown opcodes give a one-byte error result). A front end assembles
// bytes, looks up the opcode and tracks the location counter; a two-entry
// queue feeds a back end that forms the result fields, computes the target
// address and owns the base register. Sustained rate is one transfer per
// cycle while the inst channel is not held off; the back end registers a
// result as it pops the queue entry. The byte channel stalls only while the
// queue is full, which happens when the inst channel is held off. No
// clearing pass follows reset.
module sicxe_instruction_decoder_top
    import sicxe_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    byte_valid,
    output logic         byte_stall,
    input  wire dec_in_t byte_item,
    output logic         inst_valid,
    input  wire logic    inst_stall,
    output dec_out_t     inst_item
);

    logic      push;
    inst_rec_t push_rec;
    logic      pop;
    logic      q_empty;
    logic      q_full;
    inst_rec_t q_head;

    sicxe_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .push       (push),
        .push_rec   (push_rec),
        .queue_full (q_full)
    );

    sicxe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .empty    (q_empty),
        .full     (q_full),
        .head     (q_head)
    );

    sicxe_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .head        (q_head),
        .pop         (pop),
        .inst_valid  (inst_valid),
        .inst_stall  (inst_stall),
        .inst_item   (inst_item)
    );

endmodule
`default_nettype wire
